/* rtl/rfb_pkg.sv */
package rfb_pkg;

  // Largest payload that a frame may carry; longer requests saturate to it.
  localparam int MAX_PAYLOAD = 4096;

  localparam logic [7:0] SYNC_A         = 8'hF1;
  localparam logic [7:0] SYNC_B         = 8'h0E;
  localparam logic [7:0] XOR_SEED       = 8'hFF;
  localparam int         FRAME_OVERHEAD = 6;

  localparam int LEN_W   = 13;
  localparam int WIDE_W  = 17;
  localparam int TOTAL_W = 16;

  // Depth of the command queue between the front and the back part.
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic [LEN_W-1:0] payload_len;
    logic [7:0]       message_id;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } out_item_t;

  // One classified input item: everything the back part needs to emit
  // the bytes that this item causes.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] len_hi;
    logic [7:0] len_lo;
    logic [7:0] msg_id;
    logic [7:0] checksum;
    logic       is_first;
    logic       is_last;
  } cmd_t;

  // Byte slots of a frame in transmit order.
  typedef enum logic [2:0] {
    STEP_SYNC_A  = 3'd0,
    STEP_SYNC_B  = 3'd1,
    STEP_LEN_HI  = 3'd2,
    STEP_LEN_LO  = 3'd3,
    STEP_PAYLOAD = 3'd4,
    STEP_MSG_ID  = 3'd5,
    STEP_CSUM    = 3'd6
  } step_t;

endpackage

/* rtl/rfb_front.sv */
module rfb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  rfb_pkg::in_item_t in_item,
  output rfb_pkg::cmd_t     cmd
);
  import rfb_pkg::*;

  localparam logic [WIDE_W-1:0] MAX_LEN  = WIDE_W'(MAX_PAYLOAD);
  localparam logic [WIDE_W-1:0] OVERHEAD = WIDE_W'(FRAME_OVERHEAD);

  logic             in_packet_r, in_packet_nxt;
  logic [LEN_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]       running_xor_r, running_xor_nxt;
  logic [7:0]       held_id_r, held_id_nxt;

  logic [WIDE_W-1:0]  len_ext;
  logic [TOTAL_W-1:0] total;
  logic [7:0]         xor_now;
  logic               last;

  always_comb begin
    len_ext = {{(WIDE_W-LEN_W){1'b0}}, in_item.payload_len};
    if (len_ext == '0) begin
      len_ext = WIDE_W'(1);
    end
    if (len_ext > MAX_LEN) begin
      len_ext = MAX_LEN;
    end
    total = TOTAL_W'(len_ext + OVERHEAD);

    in_packet_nxt   = in_packet_r;
    bytes_left_nxt  = bytes_left_r;
    running_xor_nxt = running_xor_r;
    held_id_nxt     = held_id_r;

    if (!in_packet_r) begin
      held_id_nxt    = in_item.message_id;
      xor_now        = XOR_SEED ^ total[15:8] ^ total[7:0] ^ in_item.payload_byte;
      bytes_left_nxt = len_ext[LEN_W-1:0] - LEN_W'(1);
      last           = (bytes_left_nxt == '0);
    end else begin
      xor_now        = running_xor_r ^ in_item.payload_byte;
      last           = (bytes_left_r == LEN_W'(1));
      bytes_left_nxt = bytes_left_r - LEN_W'(1);
    end

    // The trailer checksum also covers the message id.
    cmd.payload_byte = in_item.payload_byte;
    cmd.len_hi       = total[15:8];
    cmd.len_lo       = total[7:0];
    cmd.msg_id       = held_id_nxt;
    cmd.checksum     = xor_now ^ held_id_nxt;
    cmd.is_first     = !in_packet_r;
    cmd.is_last      = last;

    if (last) begin
      in_packet_nxt   = 1'b0;
      bytes_left_nxt  = '0;
      running_xor_nxt = XOR_SEED;
    end else begin
      in_packet_nxt   = 1'b1;
      running_xor_nxt = xor_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r   <= 1'b0;
      bytes_left_r  <= '0;
      running_xor_r <= XOR_SEED;
      held_id_r     <= '0;
    end else if (accept) begin
      in_packet_r   <= in_packet_nxt;
      bytes_left_r  <= bytes_left_nxt;
      running_xor_r <= running_xor_nxt;
      held_id_r     <= held_id_nxt;
    end
  end

endmodule

/* rtl/rfb_queue.sv */
module rfb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rfb_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output rfb_pkg::cmd_t head_cmd
);
  import rfb_pkg::*;

  localparam logic [CMD_PTR_W-1:0] LAST_PTR = CMD_PTR_W'(CMD_DEPTH - 1);
  localparam logic [CMD_CNT_W-1:0] DEPTH_CNT = CMD_CNT_W'(CMD_DEPTH);

  cmd_t                 slots_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_CNT_W-1:0] count_r;
  logic                 do_push, do_pop;

  assign full     = (count_r == DEPTH_CNT);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CMD_CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/rfb_back.sv */
module rfb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  rfb_pkg::cmd_t      head_cmd,
  output logic               cmd_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output rfb_pkg::out_item_t out_item
);
  import rfb_pkg::*;

  step_t     step_r, step_nxt;
  logic      mid_r, mid_nxt;
  step_t     cur_step, first_step, last_step;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t emit_item;
  logic      room, advance;

  assign room      = !out_valid_r || out_pop;
  assign advance   = !cmd_empty && room;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    first_step = head_cmd.is_first ? STEP_SYNC_A : STEP_PAYLOAD;
    last_step  = head_cmd.is_last  ? STEP_CSUM   : STEP_PAYLOAD;
    cur_step   = mid_r ? step_r : first_step;

    emit_item.end_of_frame = 1'b0;
    unique case (cur_step)
      STEP_SYNC_A:  emit_item.frame_byte = SYNC_A;
      STEP_SYNC_B:  emit_item.frame_byte = SYNC_B;
      STEP_LEN_HI:  emit_item.frame_byte = head_cmd.len_hi;
      STEP_LEN_LO:  emit_item.frame_byte = head_cmd.len_lo;
      STEP_PAYLOAD: emit_item.frame_byte = head_cmd.payload_byte;
      STEP_MSG_ID:  emit_item.frame_byte = head_cmd.msg_id;
      STEP_CSUM: begin
        emit_item.frame_byte   = head_cmd.checksum;
        emit_item.end_of_frame = 1'b1;
      end
      default:      emit_item.frame_byte = head_cmd.payload_byte;
    endcase

    cmd_pop  = 1'b0;
    step_nxt = step_r;
    mid_nxt  = mid_r;
    if (advance) begin
      if (cur_step == last_step) begin
        cmd_pop = 1'b1;
        mid_nxt = 1'b0;
      end else begin
        step_nxt = step_t'(cur_step + 3'd1);
        mid_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= emit_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_SYNC_A;
      mid_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      mid_r  <= mid_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* rtl/response_frame_builder_core.sv */
// Response frame builder. Payload bytes enter through a queue-style port:
// an item is taken on a clock edge with in_push high and in_full low, and
// in_item carries the byte plus the length and message id, which are only
// looked at on the first byte of a packet. Framed bytes leave through a
// second queue-style port: while out_empty is low, out_item holds the
// oldest byte, and it is taken on an edge with out_pop high.
// A first byte yields five bytes (F1, 0E, length high, length low, payload),
// a middle byte yields one, and the last byte adds the message id and the
// checksum, which carries end_of_frame. A one-byte packet yields seven.
// An item's first output byte passes the command queue, then the output
// register. That register emits one byte per cycle when not stalled, so
// middle bytes flow at one item per cycle; header and trailer bytes take
// output slots too, and the four-entry command queue fills and raises
// in_full during them. A stall on the output side holds the output register;
// the queue keeps accepting until it is full. Synchronous reset (rst_n low)
// empties the queue and the output register and leaves the block waiting
// for the first byte of a new packet, with the checksum seed back at FF.
module response_frame_builder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  rfb_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output rfb_pkg::out_item_t out_item
);
  import rfb_pkg::*;

  cmd_t new_cmd;
  cmd_t head_cmd;
  logic accept;
  logic cmd_empty;
  logic cmd_pop;

  // The front part only advances its packet state on an accepted item.
  assign accept = in_push && !in_full;

  rfb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .cmd     (new_cmd)
  );

  // Classified items wait here so that output stalls do not reach the
  // front until the queue is full.
  rfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_cmd (new_cmd),
    .full     (in_full),
    .pop      (cmd_pop),
    .empty    (cmd_empty),
    .head_cmd (head_cmd)
  );

  // The back part walks each command through its byte slots.
  rfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .head_cmd  (head_cmd),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
